// ===== rtl/kkd_pkg.sv =====
`default_nettype none

package kkd_pkg;

    // Fixed field widths of the stream words and configuration registers
    localparam int KEY_IDX_W  = 4;
    localparam int KEYS_OUT_W = 16;
    localparam int THRESH_W   = 8;
    localparam int MASK_W     = 16;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd5;

    localparam logic [CFG_ADDR_W-1:0] REG_TICK_THRESHOLD  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LOW_MASK = 1'b1;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_BOUNCING = 2'd1,
        PH_PRESSED  = 2'd2
    } t_phase;

    // Per-key decision handed from the update logic to the key storage
    typedef struct packed {
        t_phase phase;
        logic   set_bit;
        logic   clr_bit;
    } t_key_ctl;

endpackage

`default_nettype wire

// ===== rtl/kkd_key_update.sv =====
`default_nettype none

module kkd_key_update
    import kkd_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  wire t_phase                 i_phase,
    input  wire logic                   i_level,
    input  wire logic [COUNT_WIDTH-1:0] i_high,
    input  wire logic [COUNT_WIDTH-1:0] i_low,
    input  wire logic [THRESH_W-1:0]    i_threshold,
    output t_key_ctl                    o_ctl,
    output logic      [COUNT_WIDTH-1:0] o_high,
    output logic      [COUNT_WIDTH-1:0] o_low
);

    localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
        bump = (&c) ? c : c + COUNT_WIDTH'(1);
    endfunction

    logic [COUNT_WIDTH-1:0] n_high_bump;
    logic [COUNT_WIDTH-1:0] n_low_bump;
    logic                   n_high_hit;
    logic                   n_low_hit;

    assign n_high_bump = bump(i_high);
    assign n_low_bump  = bump(i_low);
    assign n_high_hit  = CMP_W'(n_high_bump) >= CMP_W'(i_threshold);
    assign n_low_hit   = CMP_W'(n_low_bump) >= CMP_W'(i_threshold);

    always_comb begin
        o_ctl.phase   = i_phase;
        o_ctl.set_bit = 1'b0;
        o_ctl.clr_bit = 1'b0;
        o_high        = i_high;
        o_low         = i_low;
        case (i_phase)
            PH_BOUNCING: begin
                if (i_level) begin
                    o_low  = '0;
                    o_high = n_high_bump;
                    if (n_high_hit) begin
                        o_ctl.phase = PH_PRESSED;
                        o_high      = '0;
                    end
                end else begin
                    o_high = '0;
                    o_low  = n_low_bump;
                    if (n_low_hit) begin
                        o_ctl.phase = PH_RELEASED;
                        o_low       = '0;
                    end
                end
            end
            PH_PRESSED: begin
                if (i_level) begin
                    o_ctl.set_bit = 1'b1;
                end else begin
                    o_ctl.phase = PH_BOUNCING;
                end
            end
            default: begin
                // unused code falls in with released
                if (i_level) begin
                    o_ctl.phase = PH_BOUNCING;
                end else begin
                    o_ctl.phase   = PH_RELEASED;
                    o_ctl.clr_bit = 1'b1;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/kkd_key_bank.sv =====
`default_nettype none

module kkd_key_bank
    import kkd_pkg::*;
#(
    parameter int NUM_KEYS    = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic [KEY_IDX_W-1:0]  i_key,
    input  wire logic                  i_level,
    input  wire logic [THRESH_W-1:0]   i_threshold,
    output logic      [NUM_KEYS-1:0]   o_pressed_next,
    output t_phase                     o_phase
);

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    t_phase                 r_phase [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] r_high  [NUM_KEYS];
    logic [COUNT_WIDTH-1:0] r_low   [NUM_KEYS];
    logic [NUM_KEYS-1:0]    r_pressed;

    logic                   n_in_range;
    logic [IDX_W-1:0]       n_key_sel;
    logic [NUM_KEYS-1:0]    n_key_bit;
    logic                   n_write;
    t_phase                 n_cur_phase;
    logic [COUNT_WIDTH-1:0] n_cur_high;
    logic [COUNT_WIDTH-1:0] n_cur_low;
    t_key_ctl               n_ctl;
    logic [COUNT_WIDTH-1:0] n_high;
    logic [COUNT_WIDTH-1:0] n_low;

    assign n_in_range = 32'(i_key) < NUM_KEYS;
    assign n_key_sel  = IDX_W'(i_key);
    assign n_key_bit  = NUM_KEYS'(1) << n_key_sel;
    assign n_write    = i_en && n_in_range;

    // Out-of-range keys read as a released key with clear counters
    assign n_cur_phase = n_in_range ? r_phase[n_key_sel] : PH_RELEASED;
    assign n_cur_high  = n_in_range ? r_high[n_key_sel] : '0;
    assign n_cur_low   = n_in_range ? r_low[n_key_sel] : '0;

    kkd_key_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .i_phase     (n_cur_phase),
        .i_level     (i_level),
        .i_high      (n_cur_high),
        .i_low       (n_cur_low),
        .i_threshold (i_threshold),
        .o_ctl       (n_ctl),
        .o_high      (n_high),
        .o_low       (n_low)
    );

    always_comb begin
        o_pressed_next = r_pressed;
        if (n_write && n_ctl.set_bit) begin
            o_pressed_next = r_pressed | n_key_bit;
        end else if (n_write && n_ctl.clr_bit) begin
            o_pressed_next = r_pressed & ~n_key_bit;
        end
    end

    assign o_phase = n_in_range ? n_ctl.phase : PH_RELEASED;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_phase[k] <= PH_RELEASED;
                r_high[k]  <= '0;
                r_low[k]   <= '0;
            end
            r_pressed <= '0;
        end else if (n_write) begin
            r_phase[n_key_sel] <= n_ctl.phase;
            r_high[n_key_sel]  <= n_high;
            r_low[n_key_sel]   <= n_low;
            r_pressed          <= o_pressed_next;
        end
    end

    a_counts_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_in_range && n_cur_phase != PH_BOUNCING) |-> (n_cur_high == '0 && n_cur_low == '0))
        else $error("run counters of a settled key are not clear");

    a_one_run_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_in_range |-> (n_cur_high == '0 || n_cur_low == '0))
        else $error("high and low runs counted at once");

    a_phase_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_write |=> r_phase[$past(n_key_sel)] == $past(n_ctl.phase))
        else $error("key phase not stored after update");

endmodule

`default_nettype wire

// ===== rtl/keypad_key_debouncer_bank.sv =====
`default_nettype none

// Debouncer for a bank of keypad keys. Each input word carries one raw sample
// of one key; the key's phase (released, bouncing, pressed) and run counters
// are updated and one output word returns the debounced vector of all keys and
// the key's new phase. One word is accepted per clock while the result stream
// takes words; if the output register is full and not taken, the input word
// is held and s_axis_tready drops. An accepted word loads the input register,
// and its update, a read-modify-write of the key's phase and counters, the output register.
// Write the threshold and inversion mask only while no word is in flight.
module keypad_key_debouncer_bank
    import kkd_pkg::*;
#(
    parameter int NUM_KEYS    = 16,
    parameter int COUNT_WIDTH = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // sample stream
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,  // [3:0] key_index, [4] raw_level
    // result stream
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic      [M_TDATA_W-1:0]  o_m_axis_tdata   // [15:0] debounced_keys, [17:16] key_phase
);

    logic [THRESH_W-1:0]   r_thresh;
    logic [MASK_W-1:0]     r_mask;

    logic                  r_in_valid;
    logic [KEY_IDX_W-1:0]  r_in_key;
    logic                  r_in_level;

    logic                  r_out_valid;
    logic [KEYS_OUT_W-1:0] r_out_keys;
    t_phase                r_out_phase;

    logic                  n_s_accept;
    logic                  n_fire;
    logic                  n_level;
    logic [NUM_KEYS-1:0]   n_pressed;
    t_phase                n_phase;

    assign n_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || n_fire;
    assign n_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign n_level         = r_in_level ^ r_mask[r_in_key];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_mask   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TICK_THRESHOLD:  r_thresh <= i_cfg_wdata[THRESH_W-1:0];
                REG_ACTIVE_LOW_MASK: r_mask   <= i_cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (n_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (n_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_s_accept) begin
            r_in_key   <= i_s_axis_tdata[KEY_IDX_W-1:0];
            r_in_level <= i_s_axis_tdata[KEY_IDX_W];
        end
    end

    kkd_key_bank #(
        .NUM_KEYS    (NUM_KEYS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_bank (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (n_fire),
        .i_key          (r_in_key),
        .i_level        (n_level),
        .i_threshold    (r_thresh),
        .o_pressed_next (n_pressed),
        .o_phase        (n_phase)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_fire) begin
            r_out_keys  <= KEYS_OUT_W'(n_pressed);
            r_out_phase <= n_phase;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(M_TDATA_W - KEYS_OUT_W - 2){1'b0}}, r_out_phase, r_out_keys};

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_fire |=> r_out_valid)
        else $error("updated word lost before output register");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_in_valid && r_out_valid && !i_m_axis_tready))
        else $error("sample input stalled without a full pipeline");

    a_in_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !n_fire) |=> (r_in_valid && $stable(r_in_key)))
        else $error("held sample word dropped or changed");

endmodule

`default_nettype wire

// ===== dv/keypad_key_debouncer_bank_tb.sv =====
`default_nettype none

module keypad_key_debouncer_bank_tb;
    import kkd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NKEYS       = 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic                  level;
        logic [KEY_IDX_W-1:0]  key;
    } t_key_sample;

    typedef struct packed {
        t_phase                phase;
        logic [KEYS_OUT_W-1:0] keys;
    } t_debounce_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = REG_TICK_THRESHOLD;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;  // [3:0] key_index, [4] raw_level
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;       // [15:0] debounced_keys, [17:16] key_phase

    keypad_key_debouncer_bank u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Debouncer state mirror
    t_phase                key_phase_m [NKEYS] = '{default: PH_RELEASED};
    logic [7:0]            high_run [NKEYS] = '{default: 8'd0};
    logic [7:0]            low_run [NKEYS] = '{default: 8'd0};
    logic [KEYS_OUT_W-1:0] pressed_m = '0;
    logic [THRESH_W-1:0]   thr_cfg = THRESH_RESET;
    logic [MASK_W-1:0]     inv_mask_cfg = '0;

    t_key_sample   sample_q[$];
    t_debounce_res debounce_exp_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned err_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_debounce_res debounce_sample(logic [3:0] key, logic raw);
        logic          lvl;
        t_phase        ph;
        t_debounce_res res;
        lvl = raw ^ inv_mask_cfg[key];
        case (key_phase_m[key])
            PH_BOUNCING: begin
                if (lvl) begin
                    low_run[key] = 8'd0;
                    if (high_run[key] != 8'hFF) high_run[key] = high_run[key] + 8'd1;
                    ph = (high_run[key] >= thr_cfg) ? PH_PRESSED : PH_BOUNCING;
                end else begin
                    high_run[key] = 8'd0;
                    if (low_run[key] != 8'hFF) low_run[key] = low_run[key] + 8'd1;
                    ph = (low_run[key] >= thr_cfg) ? PH_RELEASED : PH_BOUNCING;
                end
                // leaving bouncing clears both run counters
                if (ph != PH_BOUNCING) begin
                    high_run[key] = 8'd0;
                    low_run[key]  = 8'd0;
                end
            end
            PH_PRESSED: begin
                if (lvl) begin
                    ph = PH_PRESSED;
                    pressed_m[key] = 1'b1;
                end else begin
                    ph = PH_BOUNCING;
                end
            end
            default: begin
                if (lvl) begin
                    ph = PH_BOUNCING;
                end else begin
                    ph = PH_RELEASED;
                    pressed_m[key] = 1'b0;
                end
            end
        endcase
        key_phase_m[key] = ph;
        res.keys  = pressed_m;
        res.phase = ph;
        return res;
    endfunction

    // Sample driver: hold the word until accepted, then take the next one
    always @(posedge i_clk) begin
        logic                 nxt_valid;
        logic [S_TDATA_W-1:0] nxt_data;
        t_key_sample          smp;
        nxt_valid = i_s_axis_tvalid;
        nxt_data  = i_s_axis_tdata;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                smp = t_key_sample'(i_s_axis_tdata[4:0]);
                debounce_exp_q.push_back(debounce_sample(smp.key, smp.level));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && sample_q.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                smp       = sample_q.pop_front();
                nxt_valid = 1'b1;
                nxt_data  = {3'b000, smp};
            end
        end
        i_s_axis_tvalid <= nxt_valid;
        i_s_axis_tdata  <= nxt_data;
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_debounce_res exp_res;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (debounce_exp_q.size() == 0) begin
                $error("unexpected result word %h", o_m_axis_tdata);
                err_count = err_count + 1;
            end else begin
                exp_res = debounce_exp_q.pop_front();
                if (o_m_axis_tdata[15:0] !== exp_res.keys) begin
                    $error("debounced_keys: expected %h, got %h",
                           exp_res.keys, o_m_axis_tdata[15:0]);
                    err_count = err_count + 1;
                end
                if (o_m_axis_tdata[17:16] !== exp_res.phase) begin
                    $error("key_phase: expected %0d, got %0d",
                           exp_res.phase, o_m_axis_tdata[17:16]);
                    err_count = err_count + 1;
                end
                if (o_m_axis_tdata[M_TDATA_W-1:18] !== '0) begin
                    $error("tdata padding: expected 0, got %h",
                           o_m_axis_tdata[M_TDATA_W-1:18]);
                    err_count = err_count + 1;
                end
            end
        end
    end

    task automatic queue_key_run(int unsigned key, logic lvl, int unsigned len);
        t_key_sample smp;
        smp.key   = key[3:0];
        smp.level = lvl;
        repeat (len) sample_q.push_back(smp);
    endtask

    // Check on the falling edge, once every update of the rising edge has landed
    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || i_s_axis_tvalid || debounce_exp_q.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        if (addr == REG_TICK_THRESHOLD) thr_cfg = data[THRESH_W-1:0];
        else inv_mask_cfg = data[MASK_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idle_mode(int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
        endcase
    endtask

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        logic [THRESH_W-1:0] thr_list [6];
        logic [MASK_W-1:0]   mask_list [6];
        int unsigned         n;
        int unsigned         key;
        int unsigned         len;
        logic                lvl;
        logic                paused;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset threshold of five, no inversion
        set_idle_mode(0);
        queue_key_run(0, 1'b0, 1);
        queue_key_run(0, 1'b1, 1);
        queue_key_run(0, 1'b1, 5);
        queue_key_run(0, 1'b1, 1);
        queue_key_run(0, 1'b0, 1);
        queue_key_run(0, 1'b0, 5);
        queue_key_run(15, 1'b1, 1);
        queue_key_run(15, 1'b0, 1);
        queue_key_run(15, 1'b1, 1);
        queue_key_run(0, 1'b0, 1);
        wait_for_drain();

        // Zero threshold settles on the first counted sample; all keys inverted
        write_reg(REG_TICK_THRESHOLD, 16'd0);
        write_reg(REG_ACTIVE_LOW_MASK, 16'hFFFF);
        queue_key_run(15, 1'b0, 2);
        queue_key_run(15, 1'b1, 3);
        wait_for_drain();

        // Largest threshold: run counter settles just as it reaches its maximum of 255
        write_reg(REG_TICK_THRESHOLD, 16'd255);
        write_reg(REG_ACTIVE_LOW_MASK, 16'($urandom_range(16'hFFFF)));
        set_idle_mode(3);
        key = $urandom_range(15);
        queue_key_run(key, ~inv_mask_cfg[key], 258);
        wait_for_drain();

        thr_list  = '{8'd1, 8'd3, 8'd0, 8'd2, 8'd6, 8'($urandom_range(1, 5))};
        mask_list = '{16'h0000, 16'hFFFF, 16'($urandom_range(16'hFFFF)), 16'hA5A5,
                      16'($urandom_range(16'hFFFF)), 16'h5A5A};

        for (int p = 0; p < 6; p++) begin
            write_reg(REG_TICK_THRESHOLD, {8'd0, thr_list[p]});
            write_reg(REG_ACTIVE_LOW_MASK, mask_list[p]);
            set_idle_mode(p % 4);
            n      = 0;
            paused = 1'b0;
            while (n < 50) begin
                // runs of random length on one key, some single noise samples
                key = $urandom_range(15);
                lvl = 1'($urandom_range(1));
                len = ($urandom_range(99) < 80) ? $urandom_range(1, thr_list[p] + 2) : 1;
                queue_key_run(key, lvl, len);
                n = n + len;
                if (p == 5 && !paused && n >= 25) begin
                    wait_for_drain();
                    paused = 1'b1;
                end
            end
            // stall the result side while the queue keeps offering samples
            if (p == 4) hold_req <= hold_req + 1;
            wait_for_drain();
        end

        repeat (10) @(posedge i_clk);
        if (err_count == 0 && debounce_exp_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
